// File: rtl/core/sgss_pkg.sv
package sgss_pkg;

	localparam int MAX_SLOTS_DEF = 8;
	localparam int ITEM_BITS_DEF = 32;
	localparam int ID_W = 32;
	localparam int Q_W = 17;
	localparam int T_W = 16;
	localparam int TAG_W = 8;
	localparam logic [Q_W-1:0] ONE_Q16 = 17'd65536;
	localparam logic [Q_W-1:0] PRUNE_LIMIT = 17'd6554;

	localparam logic [2:0] CFG_THRESH = 3'd0;
	localparam logic [2:0] CFG_RELOAD = 3'd1;
	localparam logic [2:0] CFG_DECAY = 3'd2;
	localparam logic [2:0] CFG_BOOST = 3'd3;
	localparam logic [2:0] CFG_SLOTS = 3'd4;

	typedef enum logic [2:0] {
		K_ADD = 3'd0,
		K_REFRESH = 3'd1,
		K_REM_ITEM = 3'd2,
		K_REM_SLOT = 3'd3,
		K_CLEAR = 3'd4,
		K_TICK = 3'd5,
		K_LOOKUP = 3'd6,
		K_NONE = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_step;
		logic apply;
		logic report;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} sts_t;

endpackage

// File: rtl/core/sgss_ctrl.sv
module sgss_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  sgss_pkg::sts_t  sts,
	output sgss_pkg::cmd_t  cmd
);
	import sgss_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.report = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: rtl/core/sgss_dp.sv
module sgss_dp #(
	parameter int MAX_SLOTS = sgss_pkg::MAX_SLOTS_DEF,
	parameter int ITEM_BITS = sgss_pkg::ITEM_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sgss_pkg::cmd_t                cmd,
	output sgss_pkg::sts_t                sts,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [16:0]                   cfg_data,
	input  logic [2:0]                    kind,
	input  logic [sgss_pkg::ID_W-1:0]     item_id,
	input  logic [sgss_pkg::TAG_W-1:0]    item_tag,
	input  logic [sgss_pkg::Q_W-1:0]      salience,
	input  logic [15:0]                   plasticity,
	input  logic [3:0]                    slot_number,
	output logic                          done,
	output logic                          accepted,
	output logic [2:0]                    slot_used,
	output logic                          evicted,
	output logic [sgss_pkg::ID_W-1:0]     evicted_item,
	output logic [sgss_pkg::Q_W-1:0]      slot_precision,
	output logic [sgss_pkg::T_W-1:0]      slot_time_left,
	output logic [sgss_pkg::TAG_W-1:0]    slot_tag,
	output logic [3:0]                    expired_count,
	output logic [3:0]                    occupied_count
);
	import sgss_pkg::*;

	localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int IW = (ITEM_BITS < ID_W) ? ITEM_BITS : ID_W;

	// configuration registers
	logic [Q_W-1:0] thresh_q, decay_q, boost_q;
	logic [T_W-1:0] reload_q;
	logic [CW-1:0]  live_q;

	// slot state
	logic [MAX_SLOTS-1:0] valid_q;
	logic [IW-1:0]        item_q [MAX_SLOTS];
	logic [TAG_W-1:0]     tag_q  [MAX_SLOTS];
	logic [Q_W-1:0]       prec_q [MAX_SLOTS];
	logic [T_W-1:0]       tim_q  [MAX_SLOTS];

	// latched request
	kind_t           kind_q;
	logic [IW-1:0]   id_q;
	logic [TAG_W-1:0] rtag_q;
	logic [Q_W-1:0]  sal_q;
	logic            gate_q;
	logic [3:0]      sn_q;

	// scan results
	logic [SW-1:0] idx_q;
	logic          hit_q, free_q;
	logic [SW-1:0] hit_slot_q, free_slot_q, low_slot_q;
	logic [Q_W-1:0] low_prec_q;
	logic [CW-1:0] drop_q;

	// result registers
	logic          done_q, acc_q, ev_q;
	logic [2:0]    su_q;
	logic [ID_W-1:0] evi_q;
	logic [Q_W-1:0] sp_q;
	logic [T_W-1:0] st_q;
	logic [TAG_W-1:0] stg_q;
	logic [3:0]    exp_q;

	logic [CW-1:0] wr_live;
	logic [Q_W-1:0] sal_sat;
	logic [32:0] prod_g;
	logic [Q_W-1:0] p_cur;
	logic [T_W-1:0] t_cur;
	logic [33:0] dec_prod;
	logic [Q_W-1:0] dec_p;
	logic [T_W-1:0] dec_t;
	logic dec_drop;
	logic in_range;
	logic [CW-1:0] act_cnt;

	always_comb begin
		if (cfg_data[3:0] == 4'd0) begin
			wr_live = CW'(1);
		end else if ({28'd0, cfg_data[3:0]} > MAX_SLOTS) begin
			wr_live = CW'(MAX_SLOTS);
		end else begin
			wr_live = CW'(cfg_data[3:0]);
		end
		sal_sat = (salience > ONE_Q16) ? ONE_Q16 : salience;
		prod_g = 33'(sal_sat) * 33'(plasticity);
		p_cur = prec_q[idx_q];
		t_cur = tim_q[idx_q];
		dec_prod = 34'(p_cur) * 34'(decay_q);
		dec_p = (dec_prod[33:16] > 18'(ONE_Q16)) ? ONE_Q16 : dec_prod[32:16];
		dec_t = (t_cur != '0) ? t_cur - 1'b1 : t_cur;
		dec_drop = (dec_p < PRUNE_LIMIT) || (dec_t == '0);
		in_range = ({1'b0, idx_q} < (SW+1)'(live_q));
		sts.scan_last = ((CW'(idx_q) + 1'b1) >= live_q) || (idx_q == SW'(MAX_SLOTS - 1));
		act_cnt = '0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			act_cnt = act_cnt + CW'(valid_q[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= 17'd32768;
			reload_q <= 16'd100;
			decay_q <= 17'd62259;
			boost_q <= 17'd13107;
			live_q <= CW'(MAX_SLOTS < 8 ? MAX_SLOTS : 8);
			valid_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.report;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_THRESH: thresh_q <= cfg_data;
					CFG_RELOAD: reload_q <= cfg_data[15:0];
					CFG_DECAY: decay_q <= cfg_data;
					CFG_BOOST: boost_q <= cfg_data;
					CFG_SLOTS: begin
						live_q <= wr_live;
						for (int i = 0; i < MAX_SLOTS; i++) begin
							if (CW'(i) >= wr_live) valid_q[i] <= 1'b0;
						end
					end
					default: ;
				endcase
			end
			if (cmd.scan_step && kind_q == K_TICK && valid_q[idx_q] && in_range) begin
				if (dec_drop) valid_q[idx_q] <= 1'b0;
			end
			if (cmd.apply) begin
				unique case (kind_q)
					K_ADD: begin
						if (gate_q && !hit_q && free_q) valid_q[free_slot_q] <= 1'b1;
					end
					K_REM_ITEM: if (hit_q) valid_q[hit_slot_q] <= 1'b0;
					K_REM_SLOT: begin
						if ({28'd0, sn_q} < 32'(live_q)) valid_q[sn_q[SW-1:0]] <= 1'b0;
					end
					K_CLEAR: valid_q <= '0;
					default: ;
				endcase
			end
		end
	end

	// payload: latch, scan, apply
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind_t'(kind);
			id_q <= item_id[IW-1:0];
			rtag_q <= item_tag;
			sal_q <= sal_sat;
			gate_q <= (prod_g >= {8'd0, thresh_q, 8'd0});
			sn_q <= slot_number;
		end
		if (cmd.scan_clr) begin
			idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hit_slot_q <= '0;
			free_slot_q <= '0;
			low_slot_q <= '0;
			low_prec_q <= prec_q[0];
			drop_q <= '0;
		end
		if (cmd.scan_step) begin
			if (!sts.scan_last) idx_q <= idx_q + 1'b1;
			if (in_range) begin
				if (valid_q[idx_q] && item_q[idx_q] == id_q && !hit_q) begin
					hit_q <= 1'b1;
					hit_slot_q <= idx_q;
				end
				if (!valid_q[idx_q] && !free_q) begin
					free_q <= 1'b1;
					free_slot_q <= idx_q;
				end
				if (p_cur < low_prec_q) begin
					low_prec_q <= p_cur;
					low_slot_q <= idx_q;
				end
				if (kind_q == K_TICK && valid_q[idx_q]) begin
					prec_q[idx_q] <= dec_p;
					tim_q[idx_q] <= dec_t;
					if (dec_drop) drop_q <= drop_q + 1'b1;
				end
			end
		end
		if (cmd.apply) begin
			acc_q <= 1'b0;
			su_q <= '0;
			ev_q <= 1'b0;
			evi_q <= '0;
			sp_q <= '0;
			st_q <= '0;
			stg_q <= '0;
			exp_q <= '0;
			unique case (kind_q)
				K_ADD, K_REFRESH: begin
					if ((kind_q == K_REFRESH || gate_q) && hit_q) begin
						acc_q <= 1'b1;
						su_q <= 3'(hit_slot_q);
						sp_q <= ((18'(prec_q[hit_slot_q]) + 18'(boost_q)) > 18'(ONE_Q16))
							? ONE_Q16 : prec_q[hit_slot_q] + boost_q;
						st_q <= reload_q;
						stg_q <= tag_q[hit_slot_q];
						prec_q[hit_slot_q] <= ((18'(prec_q[hit_slot_q]) + 18'(boost_q))
							> 18'(ONE_Q16)) ? ONE_Q16 : prec_q[hit_slot_q] + boost_q;
						tim_q[hit_slot_q] <= reload_q;
					end else if (kind_q == K_ADD && gate_q && free_q) begin
						acc_q <= 1'b1;
						su_q <= 3'(free_slot_q);
						sp_q <= sal_q;
						st_q <= reload_q;
						stg_q <= rtag_q;
						item_q[free_slot_q] <= id_q;
						tag_q[free_slot_q] <= rtag_q;
						prec_q[free_slot_q] <= sal_q;
						tim_q[free_slot_q] <= reload_q;
					end else if (kind_q == K_ADD && gate_q && sal_q > low_prec_q) begin
						acc_q <= 1'b1;
						ev_q <= 1'b1;
						evi_q <= ID_W'(item_q[low_slot_q]);
						su_q <= 3'(low_slot_q);
						sp_q <= sal_q;
						st_q <= reload_q;
						stg_q <= rtag_q;
						item_q[low_slot_q] <= id_q;
						tag_q[low_slot_q] <= rtag_q;
						prec_q[low_slot_q] <= sal_q;
						tim_q[low_slot_q] <= reload_q;
					end
				end
				K_REM_ITEM: begin
					if (hit_q) begin
						acc_q <= 1'b1;
						su_q <= 3'(hit_slot_q);
					end
				end
				K_REM_SLOT: begin
					if ({28'd0, sn_q} < 32'(live_q)) begin
						acc_q <= 1'b1;
						su_q <= sn_q[2:0];
					end
				end
				K_CLEAR: acc_q <= 1'b1;
				K_TICK: begin
					acc_q <= 1'b1;
					exp_q <= 4'(drop_q);
				end
				K_LOOKUP: begin
					if (hit_q) begin
						acc_q <= 1'b1;
						su_q <= 3'(hit_slot_q);
						sp_q <= prec_q[hit_slot_q];
						st_q <= tim_q[hit_slot_q];
						stg_q <= tag_q[hit_slot_q];
					end
				end
				default: ;
			endcase
		end
	end

	assign done = done_q;
	assign accepted = acc_q;
	assign slot_used = su_q;
	assign evicted = ev_q;
	assign evicted_item = evi_q;
	assign slot_precision = sp_q;
	assign slot_time_left = st_q;
	assign slot_tag = stg_q;
	assign expired_count = exp_q;
	assign occupied_count = 4'(act_cnt);

endmodule

// File: rtl/core/salience_gated_slot_store_top.sv
// channel   | handshake           | payload
// request   | start / busy        | kind item_id item_tag salience plasticity slot_number
// result    | done (one cycle)    | accepted slot_used evicted evicted_item slot_precision
//           |                     | slot_time_left slot_tag expired_count occupied_count
// config    | cfg_we              | cfg_index cfg_data
//
// a request runs from its accepting edge through the scan loop, which visits each
// live slot in turn, then the apply state and the report state; done is then high
// for one cycle, in which the next request may already be taken. the number of
// live slots sets how long the scan loop runs.
// arst_n clears the controller, valid bits and config; slot payload is unreset.
// the receiver cannot stall: done is high for exactly one cycle per request.
module salience_gated_slot_store_top #(
	parameter int MAX_SLOTS = sgss_pkg::MAX_SLOTS_DEF,
	parameter int ITEM_BITS = sgss_pkg::ITEM_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [31:0] item_id,
	input  logic [7:0]  item_tag,
	input  logic [16:0] salience,
	input  logic [15:0] plasticity,
	input  logic [3:0]  slot_number,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data,
	output logic        done,
	output logic        accepted,
	output logic [2:0]  slot_used,
	output logic        evicted,
	output logic [31:0] evicted_item,
	output logic [16:0] slot_precision,
	output logic [15:0] slot_time_left,
	output logic [7:0]  slot_tag,
	output logic [3:0]  expired_count,
	output logic [3:0]  occupied_count
);
	import sgss_pkg::*;

	// command and status between controller and datapath
	cmd_t cmd;
	sts_t sts;

	sgss_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	// slot store, scan loop and result registers
	sgss_dp #(.MAX_SLOTS(MAX_SLOTS), .ITEM_BITS(ITEM_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.kind(kind), .item_id(item_id), .item_tag(item_tag), .salience(salience),
		.plasticity(plasticity), .slot_number(slot_number),
		.done(done), .accepted(accepted), .slot_used(slot_used), .evicted(evicted),
		.evicted_item(evicted_item), .slot_precision(slot_precision),
		.slot_time_left(slot_time_left), .slot_tag(slot_tag),
		.expired_count(expired_count), .occupied_count(occupied_count)
	);

	// a result only follows an accepted request
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without request");

	// eviction implies the add was accepted
	a_evict_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(done && evicted) |-> accepted) else $error("eviction not accepted");

	// the controller is idle while done is shown
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy during done");

endmodule

// File: verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sgss_pkg::*;

	// one request as it crosses the start / busy handshake
	typedef struct {
		kind_t       kind;
		logic [31:0] item_id;
		logic [7:0]  item_tag;
		logic [16:0] salience;
		logic [15:0] plasticity;
		logic [3:0]  slot_number;
	} op_t;

	// one result as shown while done is high
	typedef struct packed {
		logic        accepted;
		logic [2:0]  slot_used;
		logic        evicted;
		logic [31:0] evicted_item;
		logic [16:0] slot_precision;
		logic [15:0] slot_time_left;
		logic [7:0]  slot_tag;
		logic [3:0]  expired_count;
		logic [3:0]  occupied_count;
	} outcome_t;

	// mirror of the slot store plus the queue of outcomes still owed by the block
	class slot_store_scoreboard;
		logic [16:0] thresh;
		logic [15:0] reload;
		logic [16:0] decay;
		logic [16:0] boost;
		logic [3:0]  slots_cfg;
		logic        valid [8];
		logic [31:0] item [8];
		logic [7:0]  tag [8];
		logic [16:0] prec [8];
		logic [15:0] timer [8];
		outcome_t    owed [$];
		int          errors;
		int          requests;
		int          results;
		int          evictions;
		int          expiries;

		function new();
			thresh = 17'd32768;
			reload = 16'd100;
			decay = 17'd62259;
			boost = 17'd13107;
			slots_cfg = 4'd8;
			for (int i = 0; i < 8; i++) begin
				valid[i] = 1'b0;
				item[i] = '0;
				tag[i] = '0;
				prec[i] = '0;
				timer[i] = '0;
			end
			errors = 0;
			requests = 0;
			results = 0;
			evictions = 0;
			expiries = 0;
		endfunction

		function int live();
			if (slots_cfg == 0) return 1;
			if (slots_cfg > 8) return 8;
			return slots_cfg;
		endfunction

		function void write_reg(logic [2:0] idx, logic [16:0] data);
			case (idx)
				CFG_THRESH: thresh = data;
				CFG_RELOAD: reload = data[15:0];
				CFG_DECAY:  decay = data;
				CFG_BOOST:  boost = data;
				CFG_SLOTS: begin
					slots_cfg = data[3:0];
					for (int i = live(); i < 8; i++) begin
						valid[i] = 1'b0;
						item[i] = '0;
					end
				end
				default: ;
			endcase
		endfunction

		function int find(logic [31:0] id);
			for (int i = 0; i < live(); i++)
				if (valid[i] && item[i] == id) return i;
			return -1;
		endfunction

		function void show_slot(ref outcome_t o, input int s);
			o.accepted = 1'b1;
			o.slot_used = s[2:0];
			o.slot_precision = prec[s];
			o.slot_time_left = timer[s];
			o.slot_tag = tag[s];
		endfunction

		function void bump(int s);
			logic [17:0] p;
			p = 18'(prec[s]) + 18'(boost);
			prec[s] = (p > 18'(ONE_Q16)) ? ONE_Q16 : p[16:0];
			timer[s] = reload;
		endfunction

		function void place(int s, op_t r, logic [16:0] sal);
			valid[s] = 1'b1;
			item[s] = r.item_id;
			tag[s] = r.item_tag;
			prec[s] = sal;
			timer[s] = reload;
		endfunction

		// works out the outcome of an accepted request and queues it
		function void note(op_t r);
			outcome_t    o;
			int          s;
			int          n;
			int          low;
			int          dropped;
			logic [16:0] sal;
			logic [63:0] p;
			o = '{default: '0};
			n = live();
			sal = (r.salience > ONE_Q16) ? ONE_Q16 : r.salience;
			requests++;
			case (r.kind)
				K_ADD: begin
					if (64'(sal) * 64'(r.plasticity) >= 64'(thresh) * 64'd256) begin
						s = find(r.item_id);
						if (s >= 0) begin
							bump(s);
							show_slot(o, s);
						end else begin
							for (int i = 0; i < n; i++)
								if (!valid[i] && s < 0) s = i;
							if (s >= 0) begin
								place(s, r, sal);
								show_slot(o, s);
							end else begin
								low = 0;
								for (int i = 1; i < n; i++)
									if (prec[i] < prec[low]) low = i;
								if (sal > prec[low]) begin
									o.evicted = 1'b1;
									o.evicted_item = item[low];
									evictions++;
									place(low, r, sal);
									show_slot(o, low);
								end
							end
						end
					end
				end
				K_REFRESH: begin
					s = find(r.item_id);
					if (s >= 0) begin
						bump(s);
						show_slot(o, s);
					end
				end
				K_REM_ITEM: begin
					s = find(r.item_id);
					if (s >= 0) begin
						valid[s] = 1'b0;
						item[s] = '0;
						o.accepted = 1'b1;
						o.slot_used = s[2:0];
					end
				end
				K_REM_SLOT: begin
					if (int'(r.slot_number) < n) begin
						valid[r.slot_number] = 1'b0;
						item[r.slot_number] = '0;
						o.accepted = 1'b1;
						o.slot_used = r.slot_number[2:0];
					end
				end
				K_CLEAR: begin
					for (int i = 0; i < 8; i++) begin
						valid[i] = 1'b0;
						item[i] = '0;
					end
					o.accepted = 1'b1;
				end
				K_TICK: begin
					dropped = 0;
					for (int i = 0; i < n; i++) begin
						if (valid[i]) begin
							p = (64'(prec[i]) * 64'(decay)) >> 16;
							prec[i] = (p > 64'(ONE_Q16)) ? ONE_Q16 : p[16:0];
							if (timer[i] > 0) timer[i] = timer[i] - 16'd1;
							if (prec[i] < PRUNE_LIMIT || timer[i] == 0) begin
								valid[i] = 1'b0;
								item[i] = '0;
								dropped++;
							end
						end
					end
					expiries += dropped;
					o.accepted = 1'b1;
					o.expired_count = dropped[3:0];
				end
				K_LOOKUP: begin
					s = find(r.item_id);
					if (s >= 0) show_slot(o, s);
				end
				default: ;
			endcase
			for (int i = 0; i < n; i++)
				if (valid[i]) o.occupied_count++;
			owed.insert(owed.size(), o);
		endfunction

		function void check(outcome_t got);
			outcome_t w;
			results++;
			if (owed.size() == 0) begin
				$display("%0t: result with nothing owed: acc %0b slot %0d act %0d",
					$time, got.accepted, got.slot_used, got.occupied_count);
				errors++;
				return;
			end
			w = owed.pop_front();
			if (got !== w) begin
				$display("%0t: mismatch exp acc %0b slot %0d ev %0b/%h prec %0d time %0d tag %0d exp %0d act %0d",
					$time, w.accepted, w.slot_used, w.evicted, w.evicted_item,
					w.slot_precision, w.slot_time_left, w.slot_tag, w.expired_count,
					w.occupied_count);
				$display("%0t: mismatch got acc %0b slot %0d ev %0b/%h prec %0d time %0d tag %0d exp %0d act %0d",
					$time, got.accepted, got.slot_used, got.evicted, got.evicted_item,
					got.slot_precision, got.slot_time_left, got.slot_tag, got.expired_count,
					got.occupied_count);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  kind = '0;
	logic [31:0] item_id = '0;
	logic [7:0]  item_tag = '0;
	logic [16:0] salience = '0;
	logic [15:0] plasticity = '0;
	logic [3:0]  slot_number = '0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [16:0] cfg_data = '0;
	logic        done;
	logic        accepted;
	logic [2:0]  slot_used;
	logic        evicted;
	logic [31:0] evicted_item;
	logic [16:0] slot_precision;
	logic [15:0] slot_time_left;
	logic [7:0]  slot_tag;
	logic [3:0]  expired_count;
	logic [3:0]  occupied_count;

	slot_store_scoreboard sb = new();
	int cycles = 0;
	int burst_left = 0;
	logic [31:0] id_pool [12];

	localparam int CYCLE_LIMIT = 600000;

	salience_gated_slot_store_top uut (.*);

	always #5 clk = ~clk;

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// both handshakes are sampled at the edge, before any driven update lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check('{accepted, slot_used, evicted, evicted_item, slot_precision,
					slot_time_left, slot_tag, expired_count, occupied_count});
			if (start && !busy)
				sb.note('{kind_t'(kind), item_id, item_tag, salience, plasticity,
					slot_number});
		end
	end

	// presents one request and holds it until the block takes it; the sender
	// then either goes straight on or drops start for a random gap
	task automatic send(op_t r);
		logic taken;
		start <= 1'b1;
		kind <= r.kind;
		item_id <= r.item_id;
		item_tag <= r.item_tag;
		salience <= r.salience;
		plasticity <= r.plasticity;
		slot_number <= r.slot_number;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = start && !busy;
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// end of burst: idle a while, sometimes for quite long
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) :
				$urandom_range(0, 12);
			start <= 1'b0;
			repeat ($urandom_range(1, $urandom_range(0, 1) ? 4 : 25)) @(posedge clk);
		end
	endtask

	// stop sending and let the block go quiet before a register write
	task automatic drain();
		if (start) begin
			start <= 1'b0;
			@(posedge clk);
		end
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (15) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [16:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic setup(logic [16:0] th, logic [16:0] rl, logic [16:0] dc,
			logic [16:0] bs, logic [16:0] sl);
		drain();
		write_reg(CFG_THRESH, th);
		write_reg(CFG_RELOAD, rl);
		write_reg(CFG_DECAY, dc);
		write_reg(CFG_BOOST, bs);
		write_reg(CFG_SLOTS, sl);
	endtask

	function automatic op_t mk(kind_t k, logic [31:0] id, logic [16:0] sal,
			logic [15:0] pl, logic [3:0] sn);
		op_t r;
		r.kind = k;
		r.item_id = id;
		r.item_tag = 8'($urandom);
		r.salience = sal;
		r.plasticity = pl;
		r.slot_number = sn;
		return r;
	endfunction

	// adds make the largest share, over a small id pool so slots hit, refresh and evict;
	// ticks age the store, the rest is refreshes, removes, lookups, clears and junk
	function automatic op_t random_op();
		op_t r;
		int  pick;
		pick = $urandom_range(0, 99);
		r.kind = pick < 45 ? K_ADD : pick < 55 ? K_REFRESH : pick < 62 ? K_REM_ITEM :
			pick < 67 ? K_REM_SLOT : pick < 69 ? K_CLEAR : pick < 84 ? K_TICK :
			pick < 98 ? K_LOOKUP : K_NONE;
		r.item_id = $urandom_range(0, 9) == 0 ? $urandom : id_pool[$urandom_range(0, 11)];
		r.item_tag = 8'($urandom);
		r.salience = $urandom_range(0, 9) == 0 ? 17'($urandom_range(65537, 131071)) :
			17'($urandom_range(0, 65536));
		pick = $urandom_range(0, 9);
		r.plasticity = pick == 0 ? 16'd0 : pick < 5 ? 16'($urandom_range(128, 768)) :
			16'($urandom);
		r.slot_number = 4'($urandom);
		return r;
	endfunction

	initial begin
		for (int i = 0; i < 12; i++)
			id_pool[i] = i < 2 ? (i == 0 ? 32'hFFFF_FFFF : 32'h8000_0001) : $urandom;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: gate, refresh, saturation, misses, removes, eviction, tick, clear
		send(mk(K_ADD, 32'd1, 17'd65536, 16'd256, 4'd0));
		send(mk(K_ADD, 32'd1, 17'd40000, 16'd256, 4'd0));
		send(mk(K_ADD, 32'd2, 17'h1FFFF, 16'hFFFF, 4'd0));
		send(mk(K_ADD, 32'd3, 17'd65536, 16'd0, 4'd0));
		send(mk(K_ADD, 32'd3, 17'd0, 16'hFFFF, 4'd0));
		send(mk(K_LOOKUP, 32'd1, 17'd0, 16'd1, 4'd0));
		send(mk(K_LOOKUP, 32'hFFFF_FFFF, 17'd0, 16'd1, 4'd0));
		send(mk(K_REFRESH, 32'd2, 17'd0, 16'd1, 4'd0));
		send(mk(K_REFRESH, 32'd99, 17'd0, 16'd1, 4'd0));
		send(mk(K_REM_ITEM, 32'd2, 17'd0, 16'd1, 4'd0));
		send(mk(K_REM_ITEM, 32'd2, 17'd0, 16'd1, 4'd0));
		send(mk(K_REM_SLOT, 32'd0, 17'd0, 16'd1, 4'd15));
		send(mk(K_REM_SLOT, 32'd0, 17'd0, 16'd1, 4'd3));
		send(mk(K_REM_SLOT, 32'd0, 17'd0, 16'd1, 4'd0));
		for (int i = 0; i < 8; i++)
			send(mk(K_ADD, 32'd10 + i, 17'd33000 + 17'(i * 1000), 16'd256, 4'd0));
		send(mk(K_ADD, 32'd20, 17'd65536, 16'd256, 4'd0));
		send(mk(K_ADD, 32'd21, 17'd200, 16'hFFFF, 4'd0));
		send(mk(K_TICK, 32'd0, 17'd0, 16'd1, 4'd0));
		send(mk(K_NONE, 32'd10, 17'd0, 16'd1, 4'd0));
		send(mk(K_CLEAR, 32'd0, 17'd0, 16'd1, 4'd0));

		// random phases, each under its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: setup(17'd0, 17'd0, 17'd65536, 17'd65536, 17'd0);
				1: setup(17'd65536, 17'd65535, 17'd0, 17'd0, 17'd15);
				2: setup(17'd32768, 17'd3, 17'd62259, 17'd13107, 17'd8);
				3: setup(17'($urandom_range(0, 65536)), 17'($urandom_range(1, 50)),
					17'($urandom_range(50000, 65536)), 17'($urandom_range(0, 65536)), 17'd1);
				4: setup(17'($urandom_range(0, 65536)), 17'($urandom),
					17'h1FFFF, 17'($urandom_range(0, 65536)), 17'($urandom_range(0, 15)));
				default: setup(17'd20000, 17'd40, 17'd60000, 17'd8000, 17'd8);
			endcase
			for (int i = 0; i < 200; i++) send(random_op());
		end

		// wind down: nothing owed, then let the pipeline empty
		start <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("ran %0d requests, checked %0d results", sb.requests, sb.results);
		$display("saw %0d evictions and %0d expiries over six register settings",
			sb.evictions, sb.expiries);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
